// File: rtl/rgbe_pkg.sv
// Shared types, codes and helpers of the RGBE run-length scanline decoder.
`timescale 1ns / 1ps

package rgbe_pkg;

    // Most result words that a single input byte can cause.
    localparam int unsigned RES_MAX = 5;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_HDR2,
        PH_HDR3,
        PH_CODE,
        PH_RUNVAL,
        PH_LIT,
        PH_RAW
    } phase_t;

    typedef enum logic [1:0] {
        ERR_RUN_OVF = 2'd0,
        ERR_LIT_OVF = 2'd1,
        ERR_TRUNC   = 2'd2
    } err_code_t;

    typedef enum logic [1:0] {
        CFG_LINE_WIDTH   = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } cfg_index_t;

    // Decoder state that lives between bytes.
    typedef struct packed {
        phase_t          phase;
        logic [2:0][7:0] hdr;
        logic [15:0]     column;
        logic [1:0]      lane;
        logic [7:0]      pending;
        logic [15:0]     line_counter;
        logic            halted;
    } dec_state_t;

    // One result word (the last-result flag is worked out when it is sent).
    typedef struct packed {
        logic        is_error;
        logic [1:0]  error_code;
        logic [14:0] line_index;
        logic [1:0]  channel;
        logic [14:0] x_start;
        logic [6:0]  span_count;
        logic [7:0]  byte_value;
        logic        image_done;
    } result_t;

    function automatic result_t make_write(input logic [15:0] line, input logic [1:0] ch,
                                           input logic [15:0] x, input logic [6:0] cnt,
                                           input logic [7:0] val);
        result_t r;
        r            = '0;
        r.line_index = line[14:0];
        r.channel    = ch;
        r.x_start    = x[14:0];
        r.span_count = cnt;
        r.byte_value = val;
        return r;
    endfunction

    function automatic result_t make_error(input logic [15:0] line, input err_code_t code);
        result_t r;
        r            = '0;
        r.is_error   = 1'b1;
        r.error_code = code;
        r.line_index = line[14:0];
        return r;
    endfunction

endpackage

// File: rtl/rgbe_step.sv
// Per-byte decode logic: next decoder state and the result words of one byte.
`timescale 1ns / 1ps

module rgbe_step (
    input  rgbe_pkg::dec_state_t st,
    input  logic [7:0]           data_byte,
    input  logic                 final_byte,
    input  logic [15:0]          eff_width,
    input  logic [15:0]          eff_height,
    output rgbe_pkg::dec_state_t st_next,
    output rgbe_pkg::result_t    res [rgbe_pkg::RES_MAX],
    output logic [2:0]           res_count
);

    logic [15:0] hdr_width;
    logic [16:0] span_end;
    logic [6:0]  run_len;
    logic        lane_check;
    logic        line_end;
    logic [15:0] line_next;

    assign hdr_width = {st.hdr[2], data_byte};
    assign run_len   = data_byte[6:0];

    always_comb begin
        st_next    = st;
        res_count  = 3'd0;
        lane_check = 1'b0;
        line_end   = 1'b0;
        span_end   = '0;
        line_next  = st.line_counter + 16'd1;
        for (int i = 0; i < rgbe_pkg::RES_MAX; i++) begin
            res[i] = '0;
        end

        if (!st.halted) begin
            case (st.phase)
                rgbe_pkg::PH_HDR0: begin
                    st_next.hdr[0] = data_byte;
                    st_next.phase  = rgbe_pkg::PH_HDR1;
                end
                rgbe_pkg::PH_HDR1: begin
                    st_next.hdr[1] = data_byte;
                    st_next.phase  = rgbe_pkg::PH_HDR2;
                end
                rgbe_pkg::PH_HDR2: begin
                    st_next.hdr[2] = data_byte;
                    st_next.phase  = rgbe_pkg::PH_HDR3;
                end
                rgbe_pkg::PH_HDR3: begin
                    st_next.lane = 2'd0;
                    if (eff_width >= 16'd8 && eff_width <= 16'd32767 &&
                        st.hdr[0] == 8'd2 && st.hdr[1] == 8'd2 && hdr_width == eff_width) begin
                        st_next.phase  = rgbe_pkg::PH_CODE;
                        st_next.column = 16'd0;
                    end else begin
                        // Not a run-length line: the header is the first raw pixel.
                        res[0] = rgbe_pkg::make_write(st.line_counter, 2'd0, 16'd0, 7'd1,
                                                      st.hdr[0]);
                        res[1] = rgbe_pkg::make_write(st.line_counter, 2'd1, 16'd0, 7'd1,
                                                      st.hdr[1]);
                        res[2] = rgbe_pkg::make_write(st.line_counter, 2'd2, 16'd0, 7'd1,
                                                      st.hdr[2]);
                        res[3] = rgbe_pkg::make_write(st.line_counter, 2'd3, 16'd0, 7'd1,
                                                      data_byte);
                        res_count      = 3'd4;
                        st_next.phase  = rgbe_pkg::PH_RAW;
                        st_next.column = 16'd1;
                        line_end       = (eff_width == 16'd1);
                    end
                end
                rgbe_pkg::PH_CODE: begin
                    if (data_byte > 8'd128) begin
                        span_end = {1'b0, st.column} + 17'(run_len);
                        if (span_end > {1'b0, eff_width}) begin
                            res[0]         = rgbe_pkg::make_error(st.line_counter,
                                                                  rgbe_pkg::ERR_RUN_OVF);
                            res_count      = 3'd1;
                            st_next.halted = 1'b1;
                        end else begin
                            st_next.pending = {1'b0, run_len};
                            st_next.phase   = rgbe_pkg::PH_RUNVAL;
                        end
                    end else if (data_byte != 8'd0) begin
                        span_end = {1'b0, st.column} + 17'(data_byte);
                        if (span_end > {1'b0, eff_width}) begin
                            res[0]         = rgbe_pkg::make_error(st.line_counter,
                                                                  rgbe_pkg::ERR_LIT_OVF);
                            res_count      = 3'd1;
                            st_next.halted = 1'b1;
                        end else begin
                            st_next.pending = data_byte;
                            st_next.phase   = rgbe_pkg::PH_LIT;
                        end
                    end
                end
                rgbe_pkg::PH_RUNVAL: begin
                    res[0]          = rgbe_pkg::make_write(st.line_counter, st.lane, st.column,
                                                           st.pending[6:0], data_byte);
                    res_count       = 3'd1;
                    st_next.column  = st.column + 16'(st.pending);
                    st_next.pending = 8'd0;
                    st_next.phase   = rgbe_pkg::PH_CODE;
                    lane_check      = 1'b1;
                end
                rgbe_pkg::PH_LIT: begin
                    res[0]          = rgbe_pkg::make_write(st.line_counter, st.lane, st.column,
                                                           7'd1, data_byte);
                    res_count       = 3'd1;
                    st_next.column  = st.column + 16'd1;
                    st_next.pending = st.pending - 8'd1;
                    if (st.pending == 8'd1) begin
                        st_next.phase = rgbe_pkg::PH_CODE;
                        lane_check    = 1'b1;
                    end
                end
                rgbe_pkg::PH_RAW: begin
                    res[0]    = rgbe_pkg::make_write(st.line_counter, st.lane, st.column,
                                                     7'd1, data_byte);
                    res_count = 3'd1;
                    if (st.lane == 2'd3) begin
                        st_next.lane   = 2'd0;
                        st_next.column = st.column + 16'd1;
                        line_end       = (st.column + 16'd1 >= eff_width);
                    end else begin
                        st_next.lane = st.lane + 2'd1;
                    end
                end
                default: begin
                    st_next.phase = rgbe_pkg::PH_HDR0;
                end
            endcase

            // A channel of a run-length line is full: move to the next one.
            if (lane_check && st_next.column >= eff_width) begin
                st_next.column = 16'd0;
                if (st.lane == 2'd3) begin
                    line_end = 1'b1;
                end else begin
                    st_next.lane = st.lane + 2'd1;
                end
            end

            if (line_end) begin
                st_next.line_counter = line_next;
                st_next.phase        = rgbe_pkg::PH_HDR0;
                st_next.column       = 16'd0;
                st_next.lane         = 2'd0;
                st_next.pending      = 8'd0;
                if (line_next >= eff_height) begin
                    st_next.halted                  = 1'b1;
                    res[res_count - 3'd1].image_done = 1'b1;
                end
            end

            // The stream ended before the image did.
            if (final_byte && !st_next.halted) begin
                res[res_count] = rgbe_pkg::make_error(st_next.line_counter, rgbe_pkg::ERR_TRUNC);
                res_count      = res_count + 3'd1;
                st_next.halted = 1'b1;
            end
        end
    end

endmodule

// File: rtl/rgbe_rle_scanline_decoder.sv
// Top level of the RGBE run-length scanline decoder.
`timescale 1ns / 1ps

// Decodes the pixel-data bytes of a Radiance RGBE image into pixel writes.
// Input stream (s_*): one byte per word in s_tdata, s_tlast marks the last byte
// that is available. Output stream (m_*): one write or error report per word;
// m_tlast marks the last word caused by one input byte.
// Configuration (cfg_*): register 0 is the line width, register 1 the image
// height; writes are taken in any cycle and must only be made while idle.
// Each accepted byte is decoded in the cycle it is taken and its results land
// in a five-entry result buffer, so the first result is offered in the next cycle.
// A byte that causes at most one result lets the next byte in on the following
// cycle, giving one byte per clock. The first pixel of a raw line produces four
// writes on its fourth byte, and a truncation report adds one more word; the
// buffer drains one word per cycle while the receiver is ready, and the input
// is held off until the last of them is being taken.
// When the receiver stalls, the current word holds and the input stalls with it.
// While reset is held both ready outputs stay low. After reset the decoder waits
// for the first line header; after an error or the final scanline it swallows
// all further bytes without results until reset.
module rgbe_rle_scanline_decoder #(
    parameter int MAX_WIDTH = 32768
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // final_byte
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [14:0] line_index, [16:15] channel, [31:17] x_start,
                                   // [38:32] span_count, [46:39] byte_value, [47] image_done
    output logic [2:0]  m_tuser,   // [0] is_error, [2:1] error_code
    output logic        m_tlast,   // last_result
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [16:0] MaxWidth = 17'(MAX_WIDTH);

    logic [15:0]          line_width_reg;
    logic [15:0]          image_height_reg;
    logic [15:0]          eff_width;
    logic [15:0]          eff_height;

    rgbe_pkg::dec_state_t state_reg;
    rgbe_pkg::dec_state_t state_next;
    rgbe_pkg::result_t    step_res [rgbe_pkg::RES_MAX];
    logic [2:0]           step_count;

    // Result buffer: the words of the most recent byte, sent in order.
    rgbe_pkg::result_t    buf_reg [rgbe_pkg::RES_MAX];
    logic [2:0]           count_reg;
    logic [2:0]           rd_reg;
    rgbe_pkg::result_t    cur;

    logic                 s_fire;
    logic                 m_fire;

    // The configured sizes are clamped into the range the decoder supports.
    always_comb begin
        if (line_width_reg == 16'd0) begin
            eff_width = 16'd1;
        end else if ({1'b0, line_width_reg} > MaxWidth) begin
            eff_width = MaxWidth[15:0];
        end else begin
            eff_width = line_width_reg;
        end
    end

    assign eff_height = (image_height_reg == 16'd0) ? 16'd1 : image_height_reg;

    // Register writes are taken in any cycle outside reset.
    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= 16'd1024;
            image_height_reg <= 16'd512;
        end else if (cfg_valid) begin
            case (cfg_index)
                rgbe_pkg::CFG_LINE_WIDTH:   line_width_reg   <= cfg_data;
                rgbe_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    rgbe_step u_step (
        .st         (state_reg),
        .data_byte  (s_tdata),
        .final_byte (s_tlast),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .st_next    (state_next),
        .res        (step_res),
        .res_count  (step_count)
    );

    assign cur      = buf_reg[rd_reg];
    assign m_tvalid = (rd_reg < count_reg);
    assign m_tlast  = (rd_reg == count_reg - 3'd1);
    assign m_tdata  = {cur.image_done, cur.byte_value, cur.span_count, cur.x_start,
                       cur.channel, cur.line_index};
    assign m_tuser  = {cur.error_code, cur.is_error};

    // A new byte may enter once the buffer is empty or its last word is leaving,
    // but never while reset is held.
    assign s_tready = aresetn && (!m_tvalid || (m_tready && m_tlast));
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{phase: rgbe_pkg::PH_HDR0, default: '0};
            count_reg <= 3'd0;
            rd_reg    <= 3'd0;
        end else if (s_fire) begin
            state_reg <= state_next;
            count_reg <= step_count;
            rd_reg    <= 3'd0;
        end else if (m_fire) begin
            rd_reg <= rd_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            for (int i = 0; i < rgbe_pkg::RES_MAX; i++) begin
                buf_reg[i] <= step_res[i];
            end
        end
    end

endmodule

// File: rtl/rgbe_dec_checker.sv
// Port-level checks of the RGBE scanline decoder and their binding to it.
`timescale 1ns / 1ps

module rgbe_dec_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled word holds still.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // An error report is always the final word of its byte.
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("error report not last");

    // After an error is taken the decoder is halted and sends nothing more.
    a_err_halt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser[0] |=> !m_tvalid)
        else $error("word sent after an error");

    // The completing write is the last word and never an error.
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[47] |-> m_tlast && !m_tuser[0])
        else $error("image done flag on a wrong word");

    // Writes always cover at least one pixel.
    a_span: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[38:32] != 7'd0)
        else $error("write with empty span");

endmodule

bind rgbe_rle_scanline_decoder rgbe_dec_checker u_rgbe_dec_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
